FILE: rtl/rbs_pkg.sv
// shared types, constants and arithmetic helpers for the ray/box slab test
package rbs_pkg;

  localparam int unsigned PipeDepth     = 7;
  localparam int unsigned DivStages     = 4;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned QuoWidth      = DivStages * StepsPerStage;

  localparam logic [2:0] RegBoxMinX = 3'd0;
  localparam logic [2:0] RegBoxMinY = 3'd1;
  localparam logic [2:0] RegBoxMinZ = 3'd2;
  localparam logic [2:0] RegBoxMaxX = 3'd3;
  localparam logic [2:0] RegBoxMaxY = 3'd4;
  localparam logic [2:0] RegBoxMaxZ = 3'd5;

  localparam logic signed [33:0] NegUnbounded = -34'sd2147483649;
  localparam logic signed [33:0] PosUnbounded = 34'sd2147483648;

  // one restoring divider lane
  typedef struct packed {
    logic [16:0]         rem;
    logic [QuoWidth-1:0] num;
    logic [QuoWidth-1:0] quo;
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    lane_t       mn;
    lane_t       mx;
    logic [17:0] dmag;
    logic        dneg;
    logic        dzero;
    logic        in_slab;
  } axis_t;

  typedef struct packed {
    logic signed [33:0] t0;
    logic signed [33:0] t1;
    logic               miss;
  } bound_t;

  function automatic lane_t div_steps(lane_t l, logic [17:0] d);
    lane_t       r;
    logic [17:0] t;
    r = l;
    for (int i = 0; i < StepsPerStage; i++) begin
      t     = {r.rem, r.num[QuoWidth-1]};
      r.num = {r.num[QuoWidth-2:0], 1'b0};
      if (t >= d) begin
        r.rem = 17'(t - d);
        r.quo = {r.quo[QuoWidth-2:0], 1'b1};
      end else begin
        r.rem = t[16:0];
        r.quo = {r.quo[QuoWidth-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // signed, saturated quotient from magnitude, sign and overflow flag
  function automatic logic signed [31:0] sat_quo(lane_t l);
    logic signed [31:0] r;
    if (l.neg) begin
      if (l.ovf || (l.quo > 32'h8000_0000)) r = 32'sh8000_0000;
      else r = 32'(-l.quo);
    end else begin
      if (l.ovf || l.quo[31]) r = 32'sh7fff_ffff;
      else r = l.quo;
    end
    return r;
  endfunction

endpackage

FILE: rtl/ray_box_slab_intersect.sv
// top level: ray versus axis-aligned box slab test with config registers
// path: prep register, divider stage registers, bound register, then output register
// throughput: one ray per cycle unless the output stalls; the six slab divisions run
//   as 32 restoring steps spread over four register stages, eight steps per stage
// reset: box corners clear to 0, all pipeline valid bits clear; no clearing pass
// a stall at the output backs up only as far as the first empty stage
module ray_box_slab_intersect (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // ray input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [31:0] near_distance_o
);
  import rbs_pkg::*;

  // box corner registers
  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= '0;
        bmax_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBoxMinX: bmin_q[0] <= cfg_data_i;
        RegBoxMinY: bmin_q[1] <= cfg_data_i;
        RegBoxMinZ: bmin_q[2] <= cfg_data_i;
        RegBoxMaxX: bmax_q[0] <= cfg_data_i;
        RegBoxMaxY: bmax_q[1] <= cfg_data_i;
        RegBoxMaxZ: bmax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-stage valid bits; a stage loads when it is empty or its successor loads
  logic [PipeDepth-1:0] vld_d, vld_q;
  logic [PipeDepth:0]   rdy;

  always_comb begin
    rdy[PipeDepth] = out_ready_i;
    for (int k = PipeDepth - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < PipeDepth; k++) begin
      if (rdy[k]) vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
      else vld_d[k] = vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= vld_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[PipeDepth-1];

  // datapath
  logic signed [31:0] org  [3];
  logic signed [17:0] dirv [3];
  axis_t [2:0]        stg [DivStages+1];

  assign org[0]  = origin_x_i;
  assign org[1]  = origin_y_i;
  assign org[2]  = origin_z_i;
  assign dirv[0] = dir_x_i;
  assign dirv[1] = dir_y_i;
  assign dirv[2] = dir_z_i;

  rbs_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (rdy[0]),
    .bmin_i (bmin_q),
    .bmax_i (bmax_q),
    .org_i  (org),
    .dir_i  (dirv),
    .axis_o (stg[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rbs_div_stage u_div (
      .clk_i  (clk_i),
      .en_i   (rdy[s+1]),
      .axis_i (stg[s]),
      .axis_o (stg[s+1])
    );
  end

  rbs_resolve u_resolve (
    .clk_i    (clk_i),
    .sel_en_i (rdy[DivStages+1]),
    .out_en_i (rdy[DivStages+2]),
    .axis_i   (stg[DivStages]),
    .hit_o    (hit_o),
    .near_o   (near_distance_o)
  );

  // a miss always reports zero distance
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (near_distance_o == '0))
    else $error("miss with nonzero distance");

  // back-pressure at the input only comes from a stalled, full output
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // a configuration write lands in its register
  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == RegBoxMinX)) |=> (bmin_q[0] == $past(cfg_data_i)))
    else $error("box_min_x write lost");

endmodule

FILE: rtl/rbs_prep.sv
// front stage: plane differences, magnitudes, overflow detect and divider setup
module rbs_prep (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [31:0]       bmin_i [3],
  input  logic signed [31:0]       bmax_i [3],
  input  logic signed [31:0]       org_i  [3],
  input  logic signed [17:0]       dir_i  [3],
  output rbs_pkg::axis_t [2:0]     axis_o
);
  import rbs_pkg::*;

  axis_t [2:0] axis_d, axis_q;

  function automatic lane_t lane_init(logic signed [31:0] plane, logic signed [31:0] org,
                                      logic [17:0] dmag, logic dneg);
    lane_t              l;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    diff  = 33'(plane) - 33'(org);
    mag   = diff[32] ? 32'(-diff) : diff[31:0];
    l.rem = {1'b0, mag[31:16]};
    l.num = {mag[15:0], 16'h0};
    l.quo = '0;
    l.neg = diff[32] ^ dneg;
    l.ovf = ({2'b00, mag[31:16]} >= dmag);
    return l;
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_d[a].dneg    = dir_i[a][17];
      axis_d[a].dmag    = dir_i[a][17] ? 18'(-dir_i[a]) : dir_i[a];
      axis_d[a].dzero   = (dir_i[a] == '0);
      axis_d[a].in_slab = (bmin_i[a] <= org_i[a]) && (org_i[a] <= bmax_i[a]);
      axis_d[a].mn      = lane_init(bmin_i[a], org_i[a], axis_d[a].dmag, axis_d[a].dneg);
      axis_d[a].mx      = lane_init(bmax_i[a], org_i[a], axis_d[a].dmag, axis_d[a].dneg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) axis_q <= axis_d;
  end

  assign axis_o = axis_q;

endmodule

FILE: rtl/rbs_div_stage.sv
// one divider stage: eight restoring steps on all six lanes
module rbs_div_stage (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  rbs_pkg::axis_t [2:0] axis_i,
  output rbs_pkg::axis_t [2:0] axis_o
);
  import rbs_pkg::*;

  axis_t [2:0] axis_d, axis_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_d[a]    = axis_i[a];
      axis_d[a].mn = div_steps(axis_i[a].mn, axis_i[a].dmag);
      axis_d[a].mx = div_steps(axis_i[a].mx, axis_i[a].dmag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) axis_q <= axis_d;
  end

  assign axis_o = axis_q;

endmodule

FILE: rtl/rbs_resolve.sv
// back stages: saturate and order the slab bounds, then merge the three axes
module rbs_resolve (
  input  logic                 clk_i,
  input  logic                 sel_en_i,
  input  logic                 out_en_i,
  input  rbs_pkg::axis_t [2:0] axis_i,
  output logic                 hit_o,
  output logic signed [31:0]   near_o
);
  import rbs_pkg::*;

  bound_t [2:0]       bnd_d, bnd_q;
  logic signed [33:0] lo, hi;
  logic               any_miss, hit_d;
  logic signed [31:0] near_d;
  logic               hit_q;
  logic signed [31:0] near_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (axis_i[a].dzero) begin
        bnd_d[a].t0   = NegUnbounded;
        bnd_d[a].t1   = PosUnbounded;
        bnd_d[a].miss = !axis_i[a].in_slab;
      end else if (axis_i[a].dneg) begin
        bnd_d[a].t0   = 34'(sat_quo(axis_i[a].mx));
        bnd_d[a].t1   = 34'(sat_quo(axis_i[a].mn));
        bnd_d[a].miss = 1'b0;
      end else begin
        bnd_d[a].t0   = 34'(sat_quo(axis_i[a].mn));
        bnd_d[a].t1   = 34'(sat_quo(axis_i[a].mx));
        bnd_d[a].miss = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_en_i) bnd_q <= bnd_d;
  end

  // near and far only tighten, so the final interval and the per-axis miss flags decide the hit
  always_comb begin
    lo       = NegUnbounded;
    hi       = PosUnbounded;
    any_miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (bnd_q[a].t0 > lo) lo = bnd_q[a].t0;
      if (bnd_q[a].t1 < hi) hi = bnd_q[a].t1;
      any_miss = any_miss | bnd_q[a].miss;
    end
    hit_d = !any_miss && (lo <= hi) && (hi >= 0);
    if (!hit_d) near_d = '0;
    else if (lo < -34'sd2147483648) near_d = 32'sh8000_0000;
    else near_d = lo[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) begin
      hit_q  <= hit_d;
      near_q <= near_d;
    end
  end

  assign hit_o  = hit_q;
  assign near_o = near_q;

endmodule
